>>> rtl/core/moving_average_with_slope_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for moving_average_with_slope
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_WITH_SLOPE_ASSERT_SVH
`define MOVING_AVERAGE_WITH_SLOPE_ASSERT_SVH

`ifndef SYNTHESIS
`define MAVS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define MAVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define MAVS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MAVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/mavs_pkg.sv
// ----------------------------------------------------------------------------
// mavs_pkg
// Shared widths, request codes and types of the moving average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mavs_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W      = 7;
    localparam int SAMPLE_W   = 16;
    localparam int SLOPE_W    = 17;
    localparam int SUM_W      = 22;
    localparam int CNT_W      = 5;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - SLOPE_W - SAMPLE_W;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_QUERY = 2'd2
    } act_t;

    typedef struct packed {
        act_t                        kind;
        logic signed [SAMPLE_W-1:0]  sample;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_FILL,
        ST_SLOPE_RD,
        ST_SLOPE_WR,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

>>> rtl/core/mavs_front.sv
// ----------------------------------------------------------------------------
// mavs_front
// Accepts input requests, decodes the action and queues them two deep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,   // [15:0] sample
    input  logic [1:0]      s_tuser,   // [1:0] action
    output logic            req_valid,
    input  logic            req_ready,
    output mavs_pkg::req_t  req
);
    import mavs_pkg::*;

    req_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    act_t       in_kind;
    logic       accept;
    logic       pop;

    always_comb begin
        unique case (s_tuser)
            ACT_PUSH: in_kind = ACT_PUSH;
            ACT_FILL: in_kind = ACT_FILL;
            default:  in_kind = ACT_QUERY;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign req_valid = (count_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign accept    = s_tvalid && s_tready;
    assign pop       = req_valid && req_ready;

    always_comb begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, accept} - {1'b0, pop});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            q_reg[wr_ptr_reg] <= '{kind: in_kind, sample: s_tdata};
        end
    end

endmodule

>>> rtl/core/mavs_back.sv
// ----------------------------------------------------------------------------
// mavs_back
// Executes queued requests: window store, running sum, slope, serial divide
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "moving_average_with_slope_assert.svh"

module mavs_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  mavs_pkg::req_t                    req,
    input  logic [mavs_pkg::LEN_W-1:0]        len_in,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mavs_pkg::M_TDATA_W-1:0]    m_tdata   // [15:0] average, [32:16] slope
);
    import mavs_pkg::*;

    function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] pos,
                                                   input logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0] t;
        t = {1'b0, pos} + LEN_W'(1);
        if (t >= len) begin
            return '0;
        end
        return t[ADDR_W-1:0];
    endfunction

    back_state_t                 state_reg, state_next;
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [ADDR_W-1:0]           pos_reg, pos_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [WINDOW_MAX-1:0]       valid_reg, valid_next;
    logic signed [SLOPE_W-1:0]   slope_reg, slope_next;
    logic [SUM_W-1:0]            quo_reg, quo_next;
    logic [LEN_W-1:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]            div_cnt_reg, div_cnt_next;
    logic                        neg_reg, neg_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  out_avg_reg, out_avg_next;
    logic signed [SLOPE_W-1:0]   out_slope_reg, out_slope_next;

    logic [SAMPLE_W-1:0]         sample_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0]         rd_data_reg;
    logic                        rd_valid_reg;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        mem_wr;
    logic signed [SAMPLE_W-1:0]  old_val;
    logic signed [SAMPLE_W+LEN_W:0] fill_prod;
    logic [LEN_W:0]              div_shift;
    logic                        div_ge;
    logic signed [SAMPLE_W-1:0]  sat_avg;

    assign rd_addr   = (state_reg == ST_PUSH_RD) ? pos_reg : next_pos(pos_reg, len_reg);
    assign mem_wr    = (state_reg == ST_PUSH_WR) || (state_reg == ST_FILL);
    assign old_val   = rd_valid_reg ? $signed(rd_data_reg) : '0;
    assign fill_prod = (SAMPLE_W+LEN_W+1)'(x_reg)
                     * (SAMPLE_W+LEN_W+1)'($signed({1'b0, len_reg}));
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, len_reg});

    always_comb begin
        if (!neg_reg) begin
            sat_avg = (quo_reg > SUM_W'(32767)) ? 16'sh7FFF : $signed(quo_reg[SAMPLE_W-1:0]);
        end else begin
            sat_avg = (quo_reg > SUM_W'(32768)) ? 16'sh8000 :
                      $signed(SAMPLE_W'(~quo_reg[SAMPLE_W-1:0] + SAMPLE_W'(1)));
        end
    end

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        valid_next     = valid_reg;
        slope_next     = slope_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        neg_next       = neg_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_avg_next   = out_avg_reg;
        out_slope_next = out_slope_reg;
        req_ready      = 1'b0;

        if (mem_wr) begin
            valid_next[pos_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_ready = 1'b1;
                    x_next    = req.sample;
                    len_next  = len_in;
                    unique case (req.kind)
                        ACT_PUSH: begin
                            pos_next   = next_pos(pos_reg, len_in);
                            state_next = ST_PUSH_RD;
                        end
                        ACT_FILL: begin
                            pos_next   = '0;
                            state_next = ST_FILL;
                        end
                        default: begin
                            state_next = ST_SLOPE_RD;
                        end
                    endcase
                end
            end
            ST_PUSH_RD: begin
                state_next = ST_PUSH_WR;
            end
            ST_PUSH_WR: begin
                sum_next   = SUM_W'(sum_reg + SUM_W'(x_reg) - SUM_W'(old_val));
                state_next = ST_SLOPE_RD;
            end
            ST_FILL: begin
                sum_next = fill_prod[SUM_W-1:0];
                if ({1'b0, pos_reg} == LEN_W'(len_reg - LEN_W'(1))) begin
                    pos_next   = '0;
                    state_next = ST_SLOPE_RD;
                end else begin
                    pos_next = ADDR_W'(pos_reg + ADDR_W'(1));
                end
            end
            ST_SLOPE_RD: begin
                state_next = ST_SLOPE_WR;
            end
            ST_SLOPE_WR: begin
                slope_next   = {x_reg[SAMPLE_W-1], x_reg} - {old_val[SAMPLE_W-1], old_val};
                neg_next     = sum_reg[SUM_W-1];
                quo_next     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                quo_next     = {quo_reg[SUM_W-2:0], div_ge};
                rem_next     = div_ge ? LEN_W'(div_shift - {1'b0, len_reg})
                                      : div_shift[LEN_W-1:0];
                div_cnt_next = CNT_W'(div_cnt_reg + CNT_W'(1));
                if (div_cnt_reg == CNT_W'(SUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_avg_next   = sat_avg;
                    out_slope_next = slope_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            sum_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        len_reg       <= len_next;
        slope_reg     <= slope_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        neg_reg       <= neg_next;
        out_avg_reg   <= out_avg_next;
        out_slope_reg <= out_slope_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            sample_mem[pos_reg] <= x_reg;
        end
        rd_data_reg  <= sample_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_slope_reg, out_avg_reg};

    `MAVS_ASSERT_IMPLIES(a_div_cnt_range, aclk, aresetn, state_reg == ST_DIV, div_cnt_reg <= CNT_W'(SUM_W - 1))
    `MAVS_ASSERT_IMPLIES(a_rem_below_len, aclk, aresetn, state_reg == ST_DIV, rem_reg < len_reg)
    `MAVS_ASSERT_IMPLIES(a_len_in_range, aclk, aresetn, state_reg != ST_IDLE, (len_reg != '0) && (len_reg <= LEN_W'(WINDOW_MAX)))
    `MAVS_ASSERT_NEXT(a_done_loads_out, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_tready), m_valid_reg && (state_reg == ST_IDLE))

endmodule

>>> rtl/core/moving_average_with_slope.sv
// ----------------------------------------------------------------------------
// moving_average_with_slope
// Boxcar moving average over a circular window, with slope against the
// oldest sample.
// ----------------------------------------------------------------------------
// Each request returns one result. A push passes PUSH_RD and PUSH_WR, a fill
// FILL (writing every window position), and all three actions then SLOPE_RD,
// SLOPE_WR, DIV (the 22-step serial divider of the sum by the window length)
// and DONE. Up to two requests queue at the input while one executes, and a
// finished result waits in the output register without holding up the next.
// Write window_length (1 to 64; 0 acts as 1, above 64 as 64) only while idle
// and follow every change with a fill request.
`timescale 1ns / 1ps

module moving_average_with_slope (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mavs_pkg::LEN_W-1:0]           cfg_data,   // [6:0] window_length
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,    // [15:0] sample
    input  logic [1:0]                           s_tuser,    // [1:0] action
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mavs_pkg::M_TDATA_W-1:0]       m_tdata     // [15:0] average, [32:16] slope
);
    import mavs_pkg::*;

    logic [LEN_W-1:0] window_length_reg, window_length_next;
    logic [LEN_W-1:0] eff_len;
    logic             req_valid;
    logic             req_ready;
    req_t             req;

    assign cfg_ready = 1'b1;

    always_comb begin
        window_length_next = (cfg_valid && cfg_ready) ? cfg_data : window_length_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= LEN_W'(WINDOW_MAX);
        end else begin
            window_length_reg <= window_length_next;
        end
    end

    always_comb begin
        priority if (window_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (window_length_reg > LEN_W'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = window_length_reg;
        end
    end

    mavs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    mavs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .len_in    (eff_len),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: moving_average_with_slope testbench
// Drives push, fill and query requests through the input stream. Checks every
// result against an in-bench model of the circular window, the running sum
// and the write position. Covers window lengths 0 to 127, stale state after
// a length change, sum wrap, average saturation and output backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mavs_pkg::*;

    localparam logic [1:0]          ACT_SPARE     = 2'd3;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN    = 16'h8000;
    localparam int                  RANDOM_ITEMS  = 1400;
    localparam int                  HOLD_CYCLES   = 400;
    localparam int                  IDLE_LIMIT    = 3000;
    localparam int                  SETTLE_CYCLES = 120;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SLOPE_W-1:0]  slope;
    } avg_slope_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [LEN_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic signed [SAMPLE_W-1:0] window_copy [WINDOW_MAX];
    logic [SUM_W-1:0]           sum_copy;
    int                         pos_copy;
    logic [LEN_W-1:0]           length_copy;

    avg_slope_t pending_results[$];
    int         error_count = 0;
    int         rx_hold_cycles = 0;
    bit         quiet = 1'b0;

    moving_average_with_slope uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int active_length();
        if (length_copy == 0) return 1;
        if (length_copy > WINDOW_MAX) return WINDOW_MAX;
        return int'(length_copy);
    endfunction

    function automatic int oldest_index(int pos, int len);
        return (pos + 1 >= len) ? 0 : pos + 1;
    endfunction

    function automatic avg_slope_t predict_window_result(logic [1:0] kind,
                                                         logic signed [SAMPLE_W-1:0] x);
        int         len;
        int         i;
        longint     acc;
        avg_slope_t r;
        len = active_length();
        if (kind == ACT_PUSH) begin
            pos_copy = oldest_index(pos_copy, len);
            acc = longint'($signed(sum_copy)) + longint'(x) - longint'(window_copy[pos_copy]);
            sum_copy = acc[SUM_W-1:0];
            window_copy[pos_copy] = x;
        end else if (kind == ACT_FILL) begin
            pos_copy = 0;
            acc = longint'(x) * len;
            sum_copy = acc[SUM_W-1:0];
            for (i = 0; i < len; i++) window_copy[i] = x;
        end
        acc = longint'($signed(sum_copy)) / len;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        r.average = acc[SAMPLE_W-1:0];
        acc = longint'(x) - longint'(window_copy[oldest_index(pos_copy, len)]);
        r.slope = acc[SLOPE_W-1:0];
        return r;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? random_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = value;
        s_tuser  = kind;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_window_result(kind, value));
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] len);
        wait_results_drained();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = len;
        do @(posedge aclk); while (!cfg_ready);
        length_copy = len;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_extremes_and_actions();
        send_item(ACT_QUERY, 16'd0);
        send_item(ACT_SPARE, 16'h1234);
        send_item(ACT_PUSH, SAMPLE_MAX);
        send_item(ACT_PUSH, SAMPLE_MIN);
        send_item(ACT_PUSH, 16'd1);
        send_item(ACT_PUSH, 16'hFFFF);
        send_item(ACT_FILL, SAMPLE_MIN);
        send_item(ACT_QUERY, SAMPLE_MAX);
        send_item(ACT_PUSH, SAMPLE_MAX);
        send_item(ACT_FILL, SAMPLE_MAX);
        send_item(ACT_QUERY, SAMPLE_MIN);
        send_item(ACT_SPARE, SAMPLE_MIN);
    endtask

    task automatic test_truncation();
        write_window_length(7'd3);
        send_item(ACT_FILL, 16'd0);
        send_item(ACT_PUSH, 16'hFFFF);
        send_item(ACT_PUSH, 16'hFFFF);
        send_item(ACT_PUSH, 16'hFFFF);
        send_item(ACT_PUSH, 16'd2);
        send_item(ACT_PUSH, 16'd5);
        write_window_length(7'd7);
        send_item(ACT_FILL, 16'hFFFB);
        send_item(ACT_PUSH, 16'd3);
        send_item(ACT_PUSH, 16'd3);
        send_item(ACT_QUERY, 16'd1);
    endtask

    task automatic test_length_limits();
        write_window_length(7'd0);
        send_item(ACT_FILL, 16'd100);
        send_item(ACT_PUSH, 16'hFF9C);
        send_item(ACT_PUSH, SAMPLE_MAX);
        send_item(ACT_QUERY, 16'd7);
        write_window_length(7'd127);
        send_item(ACT_FILL, 16'hFC18);
        send_item(ACT_PUSH, 16'd1);
        send_item(ACT_PUSH, SAMPLE_MIN);
        send_item(ACT_QUERY, 16'd0);
        write_window_length(7'd1);
        send_item(ACT_FILL, 16'd9);
        send_item(ACT_PUSH, 16'd10);
        write_window_length(7'd64);
        send_item(ACT_FILL, 16'd0);
    endtask

    task automatic test_length_change_without_fill();
        int i;
        send_item(ACT_FILL, SAMPLE_MAX);
        write_window_length(7'd1);
        send_item(ACT_QUERY, 16'd0);
        write_window_length(7'd64);
        send_item(ACT_FILL, SAMPLE_MIN);
        write_window_length(7'd1);
        send_item(ACT_QUERY, 16'd0);
        send_item(ACT_PUSH, 16'd5);
        write_window_length(7'd64);
        send_item(ACT_FILL, 16'd0);
        for (i = 0; i < 40; i++) send_item(ACT_PUSH, random_sample());
        write_window_length(7'd10);
        for (i = 0; i < 5; i++) send_item(ACT_PUSH, random_sample());
        send_item(ACT_QUERY, random_sample());
        write_window_length(7'd64);
        for (i = 0; i < 3; i++) send_item(ACT_PUSH, random_sample());
    endtask

    task automatic test_sum_wrap();
        int i;
        write_window_length(7'd64);
        send_item(ACT_FILL, SAMPLE_MIN);
        write_window_length(7'd63);
        send_item(ACT_FILL, SAMPLE_MAX);
        write_window_length(7'd64);
        for (i = 0; i < 64; i++) send_item(ACT_PUSH, SAMPLE_MAX);
        send_item(ACT_QUERY, 16'd0);
        send_item(ACT_FILL, SAMPLE_MAX);
        write_window_length(7'd63);
        send_item(ACT_FILL, SAMPLE_MIN);
        write_window_length(7'd64);
        for (i = 0; i < 64; i++) send_item(ACT_PUSH, SAMPLE_MIN);
        send_item(ACT_QUERY, 16'd0);
    endtask

    task automatic test_output_backpressure();
        int i;
        wait_results_drained();
        quiet = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 16; i++) send_item(2'($urandom_range(0, 2)), random_sample());
        quiet = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        int i;
        int round;
        for (round = 0; round < 3; round++) begin
            for (i = 0; i < 8; i++) send_item(2'($urandom_range(0, 3)), random_sample());
            wait_results_drained();
        end
    endtask

    task automatic test_random_phases();
        int sent;
        int count;
        int i;
        int pick;
        logic [LEN_W-1:0] len;
        logic [1:0] kind;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 7'd1;
                1: len = 7'd64;
                2: len = 7'd0;
                3: len = 7'($urandom_range(65, 127));
                default: len = 7'($urandom_range(1, 64));
            endcase
            write_window_length(len);
            if ($urandom_range(0, 9) != 0) begin
                send_item(ACT_FILL, random_sample());
                sent++;
            end
            quiet = ($urandom_range(0, 4) == 0);
            count = $urandom_range(20, 120);
            for (i = 0; i < count; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) kind = ACT_PUSH;
                else if (pick < 85) kind = ACT_QUERY;
                else if (pick < 93) kind = ACT_FILL;
                else kind = ACT_SPARE;
                send_item(kind, random_sample());
            end
            sent += count;
            quiet = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        avg_slope_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: m_tdata %h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.average) begin
                    $error("average: expected %0d, actual %0d",
                           want.average, $signed(m_tdata[15:0]));
                    error_count++;
                end
                if (m_tdata[32:16] !== want.slope) begin
                    $error("slope: expected %0d, actual %0d",
                           want.slope, $signed(m_tdata[32:16]));
                    error_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else if (quiet || $urandom_range(0, 99) < 75) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                stall = random_gap() - 1;
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= IDLE_LIMIT) begin
                $error("no handshake for %0d cycles, %0d results pending",
                       idle, pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int i;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        for (i = 0; i < WINDOW_MAX; i++) window_copy[i] = '0;
        sum_copy    = '0;
        pos_copy    = 0;
        length_copy = 7'd64;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_extremes_and_actions();
        test_truncation();
        test_length_limits();
        test_length_change_without_fill();
        test_sum_wrap();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mavs_pkg.sv
rtl/core/mavs_front.sv
rtl/core/mavs_back.sv
rtl/core/moving_average_with_slope.sv
tb/sv/tb.sv
